@@ hw/rtl/sacl_pkg.sv @@
// Package for the sample autocorrelation block: widths, command and status codes,
// and the state type of the query sequencer. It depends on nothing else.
`default_nettype none

package sacl_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int DATA_W      = 16;
    localparam int DIFF_W      = DATA_W + 1;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int DEN_W       = 2 * DATA_W + ADDR_W + 1;
    localparam int NUM_W       = DEN_W + 1;
    localparam int MAG_W       = DEN_W;
    localparam int MN_W        = MAG_W + CNT_W;
    localparam int DD_W        = DEN_W + CNT_W;
    localparam int QUO_W       = 17;
    localparam int FRAC_SH     = 13;
    localparam int REM_W       = DD_W + 1 + QUO_W + 1;
    localparam int STEP_W      = $clog2(QUO_W);
    localparam int CMD_W       = 2;
    localparam int STAT_W      = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_LAG  = 2'd1,
        STAT_FLAT = 2'd2
    } stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_SCALE,
        ST_PREP,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/sample_autocorrelation_at_lag.sv @@
// Top level of the sample autocorrelation block: sample memory, sweep pipeline,
// scaling multipliers and a restoring divider. Depends on sacl_pkg.
`default_nettype none

// How the block is used.
// Each input word (command, sample_value, lag_steps) is taken at a rising edge with
// start high and busy low. An append writes the sample into the sample memory in
// that cycle and busy stays low, so appends may follow one per cycle; appends beyond
// the capacity are dropped. A clear empties the series. Command 3 is
// ignored.
// A query gives exactly one result word, shown on correlation and status for one
// cycle with result_valid high. A lag not below the stored count answers in the
// next cycle with status 1 and busy stays low. Otherwise the block raises busy and
// sweeps the memory, reading x[i] and x[i+lag] together through two read ports,
// one index per cycle; the sweep feeds a three-stage pipeline of read, product and sum.
// Zero variance then answers at once with status 2. A valid query goes on through
// a scaling state, a preparation state and a restoring divider, which is skipped
// when the quotient saturates, and a finish state that shows the result.
// The receiver cannot stall: result words are not held. The mean register is
// written through cfg_valid/cfg_ready, always ready, and should be written while idle.
// Reset empties the series and clears the mean; memory contents are not cleared,
// as only entries below the count are ever used.
module sample_autocorrelation_at_lag (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic signed [sacl_pkg::DATA_W-1:0]   cfg_data,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic        [sacl_pkg::CMD_W-1:0]    command,
    input  wire logic signed [sacl_pkg::DATA_W-1:0]   sample_value,
    input  wire logic        [sacl_pkg::ADDR_W-1:0]   lag_steps,
    output logic                                      result_valid,
    output logic signed [sacl_pkg::DATA_W-1:0]        correlation,
    output logic        [sacl_pkg::STAT_W-1:0]        status
);
    import sacl_pkg::*;

    state_t state_reg, state_next;

    logic [DATA_W-1:0] mem [MAX_SAMPLES];

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [ADDR_W-1:0]        lag_reg;
    logic [ADDR_W-1:0]        idx_reg;
    logic signed [DATA_W-1:0] mean_reg;
    logic [DATA_W-1:0]        rd_a_reg, rd_b_reg;
    logic                     p1_valid_reg, p1_pair_reg, p2_valid_reg;
    logic signed [SQ_W-1:0]   sq_reg, cr_reg;
    logic [DEN_W-1:0]         den_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic                     neg_reg;
    logic [MN_W-1:0]          mn_reg;
    logic [DD_W-1:0]          dd_reg;
    logic [REM_W-1:0]         rem_reg, div_reg;
    logic [QUO_W-1:0]         q_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     res_valid_reg;
    logic signed [DATA_W-1:0] res_corr_reg;
    logic [STAT_W-1:0]        res_stat_reg;

    logic                     accept, do_append, do_clear, q_ok, q_bad;
    logic [ADDR_W-1:0]        addr_b;
    logic                     pair_now, sweep_last, pipe_empty, den_zero;
    logic signed [DIFF_W-1:0] d_val, e_val;
    logic [MAG_W-1:0]         mag;
    logic [REM_W-1:0]         nn, dd2, lim;
    logic                     sat, ge;
    logic signed [DATA_W-1:0] final_corr;
    logic                     sweep_en, res_load;
    logic [STAT_W-1:0]        res_stat;
    logic signed [DATA_W-1:0] res_corr;

    assign cfg_ready = 1'b1;

    assign accept    = start && !busy;
    assign do_append = accept && (command == CMD_APPEND);
    assign do_clear  = accept && (command == CMD_CLEAR);
    assign q_ok      = accept && (command == CMD_QUERY) && ({1'b0, lag_steps} < count_reg);
    assign q_bad     = accept && (command == CMD_QUERY) && ({1'b0, lag_steps} >= count_reg);

    assign addr_b     = idx_reg + lag_reg;
    assign pair_now   = {1'b0, idx_reg} < (n_reg - {1'b0, lag_reg});
    assign sweep_last = {1'b0, idx_reg} == (n_reg - CNT_W'(1));
    assign pipe_empty = !p1_valid_reg && !p2_valid_reg;
    assign den_zero   = den_reg == '0;

    // Deviations from the mean, one guard bit wider than the samples.
    assign d_val = DIFF_W'(signed'(rd_a_reg)) - DIFF_W'(mean_reg);
    assign e_val = DIFF_W'(signed'(rd_b_reg)) - DIFF_W'(mean_reg);

    // Magnitude of the finished numerator, taken during the scaling cycle.
    assign mag = (num_reg < 0) ? MAG_W'(-num_reg) : MAG_W'(num_reg);

    // Numerator carries the half-divisor so that truncating division rounds to nearest.
    assign nn  = (REM_W'(mn_reg) << FRAC_SH) + REM_W'(dd_reg);
    assign dd2 = REM_W'(dd_reg) << 1;
    assign lim = dd2 << QUO_W;
    assign sat = nn >= lim;
    assign ge  = rem_reg >= div_reg;

    always_comb
    begin
        if (neg_reg)
        begin
            final_corr = (q_reg > QUO_W'(32768)) ? DATA_W'(-32768)
                                                 : DATA_W'(-$signed({1'b0, q_reg}));
        end
        else
        begin
            final_corr = (q_reg > QUO_W'(32767)) ? DATA_W'(32767) : DATA_W'(q_reg);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (q_ok) state_next = ST_SWEEP;
            ST_SWEEP:  if (sweep_last) state_next = ST_DRAIN;
            ST_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = den_zero ? ST_IDLE : ST_SCALE;
                end
            end
            ST_SCALE:  state_next = ST_PREP;
            ST_PREP:   state_next = sat ? ST_FINISH : ST_DIVIDE;
            ST_DIVIDE: if (step_reg == '0) state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        busy     = 1'b1;
        sweep_en = 1'b0;
        res_load = 1'b0;
        res_stat = STAT_OK;
        res_corr = '0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (q_bad)
                begin
                    res_load = 1'b1;
                    res_stat = STAT_LAG;
                end
            end
            ST_SWEEP:  sweep_en = 1'b1;
            ST_DRAIN:
            begin
                if (pipe_empty && den_zero)
                begin
                    res_load = 1'b1;
                    res_stat = STAT_FLAT;
                end
            end
            ST_FINISH:
            begin
                res_load = 1'b1;
                res_corr = final_corr;
            end
            default:   busy = 1'b1;
        endcase
    end

    // Sample memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (do_append && (count_reg < CNT_W'(MAX_SAMPLES)))
        begin
            mem[count_reg[ADDR_W-1:0]] <= sample_value;
        end
        rd_a_reg <= mem[idx_reg];
        rd_b_reg <= mem[addr_b];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            mean_reg      <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p1_valid_reg  <= sweep_en;
            p2_valid_reg  <= p1_valid_reg;
            res_valid_reg <= res_load;
            if (cfg_valid && cfg_ready)
            begin
                mean_reg <= cfg_data;
            end
            if (do_clear)
            begin
                count_reg <= '0;
            end
            else if (do_append && (count_reg < CNT_W'(MAX_SAMPLES)))
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        p1_pair_reg <= pair_now;
        sq_reg      <= d_val * d_val;
        if (p1_pair_reg)
        begin
            cr_reg <= d_val * e_val;
        end
        else
        begin
            cr_reg <= '0;
        end
        if (res_load)
        begin
            res_corr_reg <= res_corr;
            res_stat_reg <= res_stat;
        end
        case (state_reg)
            ST_IDLE:
            begin
                idx_reg <= '0;
                lag_reg <= lag_steps;
                n_reg   <= count_reg;
                den_reg <= '0;
                num_reg <= '0;
            end
            ST_SWEEP, ST_DRAIN:
            begin
                if (sweep_en)
                begin
                    idx_reg <= idx_reg + ADDR_W'(1);
                end
                if (p2_valid_reg)
                begin
                    den_reg <= den_reg + DEN_W'(sq_reg);
                    num_reg <= num_reg + NUM_W'(cr_reg);
                end
                neg_reg <= 1'b0;
            end
            ST_SCALE:
            begin
                neg_reg <= num_reg < 0;
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
        if (state_reg == ST_SCALE)
        begin
            mn_reg <= MN_W'(mag) * MN_W'(n_reg);
            dd_reg <= DD_W'(n_reg - {1'b0, lag_reg}) * DD_W'(den_reg);
        end
        if (state_reg == ST_PREP)
        begin
            rem_reg  <= nn;
            div_reg  <= dd2 << (QUO_W - 1);
            q_reg    <= sat ? '1 : '0;
            step_reg <= STEP_W'(QUO_W - 1);
        end
        else if (state_reg == ST_DIVIDE)
        begin
            rem_reg  <= ge ? (rem_reg - div_reg) : rem_reg;
            q_reg    <= {q_reg[QUO_W-2:0], ge};
            div_reg  <= div_reg >> 1;
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    assign result_valid = res_valid_reg;
    assign correlation  = res_corr_reg;
    assign status       = res_stat_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sacl_checker.sv @@
// Port-level checker for the sample autocorrelation block, bound to its top level.
// Depends on sacl_pkg.
`default_nettype none

module sacl_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 start,
    input wire logic                                 busy,
    input wire logic        [sacl_pkg::CMD_W-1:0]    command,
    input wire logic                                 result_valid,
    input wire logic signed [sacl_pkg::DATA_W-1:0]   correlation,
    input wire logic        [sacl_pkg::STAT_W-1:0]   status
);
    import sacl_pkg::*;

    // An error word always carries a zero correlation.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != STAT_OK) |-> correlation == '0)
        else $error("error status with nonzero correlation");

    // Appends and clears give no result word.
    a_append_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_APPEND || command == CMD_CLEAR)) |=> !result_valid)
        else $error("result after append or clear");

    // A query either answers at once or makes the block busy.
    a_query_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_QUERY) |=> (busy || result_valid))
        else $error("query neither answered nor started");

    // Busy rises only after a query is taken.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && command == CMD_QUERY))
        else $error("busy without a query");

endmodule

bind sample_autocorrelation_at_lag sacl_checker u_sacl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .result_valid (result_valid),
    .correlation  (correlation),
    .status       (status)
);

`default_nettype wire

@@ tb/autocorr_checker.sv @@
// Checker for the sample autocorrelation block: it watches the command, mean and
// result channels, predicts each result word and compares it field by field.
// Depends on sacl_pkg for widths and the command and status codes.
module autocorr_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic signed [sacl_pkg::DATA_W-1:0] cfg_data,
    input  logic                               start,
    input  logic                               busy,
    input  logic        [sacl_pkg::CMD_W-1:0]  command,
    input  logic signed [sacl_pkg::DATA_W-1:0] sample_value,
    input  logic        [sacl_pkg::ADDR_W-1:0] lag_steps,
    input  logic                               result_valid,
    input  logic signed [sacl_pkg::DATA_W-1:0] correlation,
    input  logic        [sacl_pkg::STAT_W-1:0] status,
    output int                                 fail_count,
    output int                                 pending
);
    import sacl_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] corr;
        stat_t                    stat;
    } acf_word_t;

    logic signed [DATA_W-1:0] series_q [0:MAX_SAMPLES-1];
    int unsigned              stored_n;
    logic signed [DATA_W-1:0] mean_q;
    acf_word_t                acf_expect_q [$];

    function automatic acf_word_t predict_acf(input int unsigned lag);
        acf_word_t    w;
        longint       num;
        longint       den;
        longint       d;
        longint       e;
        longint       mag;
        longint       qi;
        logic [127:0] dd;
        logic [127:0] nn;
        logic [127:0] q;
        w.corr = '0;
        num    = 0;
        den    = 0;
        if (lag >= stored_n)
        begin
            w.stat = STAT_LAG;
            return w;
        end
        for (int unsigned i = 0; i < stored_n; i++)
        begin
            d   = longint'(series_q[i]) - longint'(mean_q);
            den += d * d;
            if (i < stored_n - lag)
            begin
                e   = longint'(series_q[i + lag]) - longint'(mean_q);
                num += d * e;
            end
        end
        if (den == 0)
        begin
            w.stat = STAT_FLAT;
            return w;
        end
        // Rounded to nearest, ties away from zero, on the magnitude.
        mag = (num < 0) ? -num : num;
        dd  = 128'(stored_n - lag) * 128'(den);
        nn  = 128'(mag) * 128'(stored_n) * 128'd8192 + dd;
        q   = nn / (dd << 1);
        qi  = (q > 128'h1FFFF) ? 64'h1FFFF : longint'(q[63:0]);
        if (num < 0)
            w.corr = (qi > 32768) ? -16'sd32768 : DATA_W'(-qi);
        else
            w.corr = (qi > 32767) ? 16'sd32767 : DATA_W'(qi);
        w.stat = STAT_OK;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        acf_word_t want;
        if (!rst_n)
        begin
            stored_n   = 0;
            mean_q     = '0;
            fail_count = 0;
            acf_expect_q.delete();
        end
        else
        begin
            // Results are checked before new words, so a query taken at this edge
            // cannot be matched against a result shown in the same cycle.
            if (result_valid)
            begin
                if (acf_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected result word: correlation %0d status %0d",
                             $time, correlation, status);
                    fail_count++;
                end
                else
                begin
                    want = acf_expect_q.pop_front();
                    if (correlation !== want.corr)
                    begin
                        $display("%0t: correlation mismatch: expected %0d actual %0d",
                                 $time, want.corr, correlation);
                        fail_count++;
                    end
                    if (status !== want.stat)
                    begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.stat, status);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                mean_q = cfg_data;
            if (start && !busy)
            begin
                case (command)
                    CMD_APPEND:
                    begin
                        if (stored_n < MAX_SAMPLES)
                        begin
                            series_q[stored_n] = sample_value;
                            stored_n++;
                        end
                    end
                    CMD_QUERY: acf_expect_q.push_back(predict_acf(lag_steps));
                    CMD_CLEAR: stored_n = 0;
                    default: ;
                endcase
            end
        end
        pending = acf_expect_q.size();
    end

endmodule

@@ tb/testbench.sv @@
// Top of the testbench for sample_autocorrelation_at_lag: clock, reset, stimulus and
// the verdict. Depends on sacl_pkg and on autocorr_checker, which checks every result word.
module testbench;
    import sacl_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic signed [DATA_W-1:0] cfg_data;
    logic                     start;
    logic                     busy;
    logic        [CMD_W-1:0]  command;
    logic signed [DATA_W-1:0] sample_value;
    logic        [ADDR_W-1:0] lag_steps;
    logic                     result_valid;
    logic signed [DATA_W-1:0] correlation;
    logic        [STAT_W-1:0] status;
    int                       fail_count;
    int                       pending;

    // Words sent that the block does not merely ignore.
    int                       words_sent;
    // Words left in the current burst; at zero the sender picks a new burst and may take a random gap.
    int                       burst_left;
    int                       full_fills;
    logic signed [DATA_W-1:0] cur_mean;

    localparam cmd_t CMD_UNUSED = cmd_t'(2'd3);

    sample_autocorrelation_at_lag i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .sample_value (sample_value),
        .lag_steps    (lag_steps),
        .result_valid (result_valid),
        .correlation  (correlation),
        .status       (status)
    );

    autocorr_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .sample_value (sample_value),
        .lag_steps    (lag_steps),
        .result_valid (result_valid),
        .correlation  (correlation),
        .status       (status),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Presents one word and holds it until the block takes it. Start is left high,
    // so a following word goes out back to back; the burst logic lowers it for gaps.
    task automatic send_word(input cmd_t cmd, input logic signed [DATA_W-1:0] val,
                             input int unsigned lag);
        start        <= 1'b1;
        command      <= cmd;
        sample_value <= val;
        lag_steps    <= ADDR_W'(lag);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (cmd != CMD_UNUSED)
            words_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            // Occasional long runs without any gap, otherwise short bursts.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 6);
            if ($urandom_range(0, 2) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12))
                    @(posedge clk);
            end
        end
    endtask

    // The block is idle once every expected word has come and busy is low. The trailing
    // wait covers a lag error answer that is still on its way.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_mean(input logic signed [DATA_W-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_mean  = val;
    endtask

    // One well-formed series: clear, append, then a few queries. Flat series make
    // every deviation zero; a rare fill reaches or runs past the capacity.
    task automatic run_series();
        int unsigned len;
        int unsigned lag;
        int          kind;
        logic signed [DATA_W-1:0] val;
        kind = $urandom_range(0, 19);
        if (kind == 0 && full_fills < 3)
        begin
            len = $urandom_range(MAX_SAMPLES, MAX_SAMPLES + 8);
            full_fills++;
        end
        else if (kind < 4)
            len = $urandom_range(1, 200);
        else
            len = $urandom_range(1, 32);
        send_word(CMD_CLEAR, DATA_W'($urandom), $urandom);
        for (int unsigned i = 0; i < len; i++)
        begin
            if (kind == 1)
                val = cur_mean;
            else if (kind == 2)
                val = cur_mean + DATA_W'($urandom_range(0, 600)) - 16'sd300;
            else
                val = DATA_W'($urandom);
            send_word(CMD_APPEND, val, $urandom);
        end
        repeat ($urandom_range(1, 3))
        begin
            if ($urandom_range(0, 5) == 0)
                lag = $urandom_range(0, 1023);
            else
                lag = $urandom_range(0, (len > 1024 ? 1024 : len) - 1);
            send_word(CMD_QUERY, DATA_W'($urandom), lag);
        end
    endtask

    // Random words of any command, including the unused one.
    task automatic run_noise();
        repeat ($urandom_range(1, 10))
            send_word(cmd_t'($urandom_range(0, 3)), DATA_W'($urandom),
                      $urandom_range(0, 1023));
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        start        = 1'b0;
        command      = CMD_APPEND;
        sample_value = '0;
        lag_steps    = '0;
        words_sent   = 0;
        burst_left   = 0;
        full_fills   = 0;
        cur_mean     = '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An empty store answers with a lag error, even at lag zero.
        send_word(CMD_QUERY, 16'sd0, 0);
        // Two spikes at the ends of the series: the normalised value exceeds the
        // Q3.12 range, so it clamps high, and with opposite signs it clamps low.
        send_word(CMD_APPEND, 16'sd100, 0);
        repeat (18)
            send_word(CMD_APPEND, 16'sd0, 0);
        send_word(CMD_APPEND, 16'sd100, 0);
        send_word(CMD_QUERY, 16'sd0, 19);
        send_word(CMD_QUERY, 16'sd0, 20);
        send_word(CMD_QUERY, 16'sd0, 1023);
        send_word(CMD_QUERY, 16'sd0, 0);
        send_word(CMD_CLEAR, 16'sd0, 0);
        send_word(CMD_APPEND, -16'sd100, 0);
        repeat (18)
            send_word(CMD_APPEND, 16'sd0, 0);
        send_word(CMD_APPEND, 16'sd100, 0);
        send_word(CMD_QUERY, 16'sd0, 19);
        // The unused command changes nothing.
        send_word(CMD_UNUSED, 16'sd1, 1);
        send_word(CMD_QUERY, 16'sd0, 1);

        // Extreme samples against the most negative mean, then a flat series.
        write_mean(-16'sd32768);
        send_word(CMD_CLEAR, 16'sd0, 0);
        send_word(CMD_APPEND, 16'sd32767, 0);
        send_word(CMD_APPEND, -16'sd32768, 0);
        send_word(CMD_APPEND, 16'sd32767, 0);
        send_word(CMD_QUERY, 16'sd0, 1);
        send_word(CMD_QUERY, 16'sd0, 2);
        send_word(CMD_CLEAR, 16'sd0, 0);
        send_word(CMD_APPEND, -16'sd32768, 0);
        send_word(CMD_APPEND, -16'sd32768, 0);
        send_word(CMD_QUERY, 16'sd0, 0);

        // Random part, in phases under different means, the extremes among them.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_mean(16'sd0);
                1: write_mean(16'sd32767);
                2: write_mean(-16'sd32768);
                default: write_mean(DATA_W'($urandom));
            endcase
            while (words_sent < 250 + phase * 260)
            begin
                if ($urandom_range(0, 4) == 0)
                    run_noise();
                else
                    run_series();
            end
        end

        wait_idle();
        repeat (40)
            @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #50000000;
        $display("status: fail");
        $finish;
    end

endmodule
